FILE: rtl/s2u_pkg.sv
`timescale 1ns / 1ps

package s2u_pkg;

	// Reset value of the base register
	localparam logic [5:0] RADIX_RESET = 6'd10;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADBASE = 2'd1;
	localparam logic [1:0] ST_NODIG   = 2'd2;
	localparam logic [1:0] ST_OVF     = 2'd3;

	// Classified character, front to back
	typedef struct packed {
		logic       is_nul;
		logic       is_space;
		logic       is_plus;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic       dig_ok;
		logic [5:0] dig;
	} s2u_cls_t;

endpackage

FILE: rtl/s2u_front.sv
`timescale 1ns / 1ps

module s2u_front (
	input  logic              char_valid,
	output logic              char_stall,
	input  logic [7:0]        char_byte,
	input  logic              q_full,
	output logic              q_push,
	output s2u_pkg::s2u_cls_t q_item
);
	import s2u_pkg::*;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	// subtract to map letters onto 10..35
	localparam logic [7:0] OFS_UC   = 8'h37;
	localparam logic [7:0] OFS_LC   = 8'h57;

	logic [7:0] dsub;

	always_comb begin
		q_item          = '0;
		q_item.is_nul   = (char_byte == CH_NUL);
		q_item.is_space = (char_byte == CH_SPACE) ||
			(char_byte >= CH_HT && char_byte <= CH_CR);
		q_item.is_plus  = (char_byte == CH_PLUS);
		q_item.is_minus = (char_byte == CH_MINUS);
		q_item.is_zero  = (char_byte == CH_0);
		q_item.is_x     = (char_byte == CH_LX) || (char_byte == CH_UX);
		dsub            = '0;
		if (char_byte >= CH_0 && char_byte <= CH_9) begin
			dsub          = char_byte - CH_0;
			q_item.dig_ok = 1'b1;
		end else if (char_byte >= CH_UA && char_byte <= CH_UZ) begin
			dsub          = char_byte - OFS_UC;
			q_item.dig_ok = 1'b1;
		end else if (char_byte >= CH_LA && char_byte <= CH_LZ) begin
			dsub          = char_byte - OFS_LC;
			q_item.dig_ok = 1'b1;
		end
		q_item.dig = dsub[5:0];
	end

	assign char_stall = q_full;
	assign q_push     = char_valid && !q_full;

endmodule

FILE: rtl/s2u_queue.sv
`timescale 1ns / 1ps

module s2u_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  s2u_pkg::s2u_cls_t wr_item,
	output logic              full,
	input  logic              pop,
	output logic              rd_valid,
	output s2u_pkg::s2u_cls_t rd_item
);
	import s2u_pkg::*;

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);

	s2u_cls_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     cnt_q;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/s2u_back.sv
`timescale 1ns / 1ps

module s2u_back #(
	parameter int POSITION_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [5:0]        radix,
	input  logic              q_valid,
	input  s2u_pkg::s2u_cls_t q_item,
	output logic              q_pop,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [63:0]       value,
	output logic [1:0]        status,
	output logic [15:0]       stop_index
);
	import s2u_pkg::*;

	localparam int PW = POSITION_WIDTH;

	localparam logic [2:0] PH_WS     = 3'd0;
	localparam logic [2:0] PH_FIRST  = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_X      = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_STOP   = 3'd5;

	localparam logic [5:0] BASE_MIN = 6'd2;
	localparam logic [5:0] BASE_OCT = 6'd8;
	localparam logic [5:0] BASE_DEC = 6'd10;
	localparam logic [5:0] BASE_HEX = 6'd16;
	localparam logic [5:0] BASE_MAX = 6'd36;

	logic [2:0]    phase_q, n_phase;
	logic          minus_q, n_minus;
	logic          ovf_q, n_ovf;
	logic [63:0]   acc_q, n_acc;
	logic [5:0]    base_q, n_base;
	logic [PW-1:0] pos_q, n_pos;
	logic [PW-1:0] stop_q, n_stop;
	logic          digits_q, n_digits;

	logic          go;
	logic          r_auto, r_hex, dec_zero, dec_bad, dec_path, do_take, td_ok;
	logic [5:0]    dec_base, td_base;
	logic [5:0]    end_base;
	logic [63:0]   td_acc;
	logic [69:0]   prod;
	logic [PW-1:0] pos_inc;

	logic          res_valid_q;
	logic [63:0]   value_q;
	logic [1:0]    status_q;
	logic [15:0]   sidx_q;
	logic [15:0]   sp16;

	// clamp stop position onto the 16-bit result field
	if (PW > 16) begin : g_sat
		assign sp16 = (stop_q[PW-1:16] != '0) ? 16'hFFFF : stop_q[15:0];
	end else begin : g_ext
		assign sp16 = 16'(stop_q);
	end

	always_comb begin
		// a NUL needs the output register free; other chars never wait
		go    = q_valid && (!q_item.is_nul || !res_valid_q || !res_stall);
		q_pop = go;

		r_auto   = (radix == '0);
		r_hex    = (radix == BASE_HEX);
		dec_zero = (r_auto || r_hex) && q_item.is_zero;
		dec_base = r_auto ? BASE_DEC : radix;
		dec_bad  = !r_auto && (radix < BASE_MIN || radix > BASE_MAX);
		dec_path = (phase_q == PH_FIRST) || ((phase_q == PH_WS) &&
			!q_item.is_space && !q_item.is_plus && !q_item.is_minus);

		td_base = (phase_q == PH_X) ? BASE_HEX : (dec_path ? dec_base : base_q);
		td_acc  = (phase_q == PH_X) ? '0 : acc_q;
		td_ok   = q_item.dig_ok && (q_item.dig < td_base);
		// acc * base + digit, carry bits give exact overflow
		prod    = 70'(td_acc) * 70'(td_base) + 70'(q_item.dig);
		pos_inc = (pos_q == '1) ? pos_q : pos_q + 1'b1;

		n_phase  = phase_q;
		n_minus  = minus_q;
		n_ovf    = ovf_q;
		n_acc    = acc_q;
		n_base   = base_q;
		n_stop   = stop_q;
		n_digits = digits_q;
		n_pos    = pos_inc;
		do_take  = 1'b0;

		unique case (phase_q) inside
			PH_WS, PH_FIRST: begin
				if ((phase_q == PH_WS) && q_item.is_space) begin
					n_phase = phase_q;
				end else if ((phase_q == PH_WS) && (q_item.is_plus || q_item.is_minus)) begin
					n_minus = q_item.is_minus;
					n_phase = PH_FIRST;
				end else if (dec_zero) begin
					n_base   = r_auto ? BASE_OCT : BASE_HEX;
					n_acc    = '0;
					n_digits = 1'b1;
					n_stop   = pos_inc;
					n_phase  = PH_ZERO;
				end else if (dec_bad) begin
					n_base  = '0;
					n_phase = PH_STOP;
				end else begin
					n_base  = dec_base;
					do_take = 1'b1;
				end
			end
			PH_ZERO: begin
				if (q_item.is_x) begin
					n_phase = PH_X;
				end else begin
					do_take = 1'b1;
				end
			end
			PH_X: begin
				if (td_ok) begin
					n_base  = BASE_HEX;
					n_ovf   = 1'b0;
					do_take = 1'b1;
				end else begin
					n_phase = PH_STOP;
				end
			end
			PH_DIGITS: begin
				do_take = 1'b1;
			end
			default: begin
				n_phase = phase_q;
			end
		endcase

		if (do_take) begin
			if (td_ok) begin
				n_acc    = prod[63:0];
				n_ovf    = n_ovf || (prod[69:64] != '0);
				n_digits = 1'b1;
				n_stop   = pos_inc;
				n_phase  = PH_DIGITS;
			end else begin
				n_phase = PH_STOP;
			end
		end

		// base as the terminating NUL leaves it, before the string is cleared
		end_base = n_base;

		// end of string: back to the initial state
		if (q_item.is_nul) begin
			n_phase  = PH_WS;
			n_minus  = 1'b0;
			n_ovf    = 1'b0;
			n_acc    = '0;
			n_base   = '0;
			n_pos    = '0;
			n_stop   = '0;
			n_digits = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WS;
			minus_q  <= 1'b0;
			ovf_q    <= 1'b0;
			acc_q    <= '0;
			base_q   <= '0;
			pos_q    <= '0;
			stop_q   <= '0;
			digits_q <= 1'b0;
		end else if (go) begin
			phase_q  <= n_phase;
			minus_q  <= n_minus;
			ovf_q    <= n_ovf;
			acc_q    <= n_acc;
			base_q   <= n_base;
			pos_q    <= n_pos;
			stop_q   <= n_stop;
			digits_q <= n_digits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && q_item.is_nul) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// a NUL never changes acc, digits or overflow; only the base can
	always_ff @(posedge clk) begin
		if (go && q_item.is_nul) begin
			if (end_base == '0) begin
				value_q  <= '0;
				status_q <= ST_BADBASE;
				sidx_q   <= '0;
			end else if (!digits_q) begin
				value_q  <= '0;
				status_q <= ST_NODIG;
				sidx_q   <= '0;
			end else if (ovf_q) begin
				value_q  <= '1;
				status_q <= ST_OVF;
				sidx_q   <= sp16;
			end else begin
				value_q  <= minus_q ? (64'd0 - acc_q) : acc_q;
				status_q <= ST_OK;
				sidx_q   <= sp16;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign value      = value_q;
	assign status     = status_q;
	assign stop_index = sidx_q;

endmodule

FILE: rtl/string_to_u64_parser_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// char      in         char_valid/char_stall   char_byte[7:0]
// result    out        res_valid/res_stall     value[63:0], status[1:0], stop_index[15:0]
// radix     cfg        radix_wr_en             radix_wr_data[5:0]
//
// One character per cycle while char_stall is low; a request reaches the parser state
// through the queue write, then the 64x6 multiply-add at the pop edge.
// A NUL request loads the output register at the edge it leaves the queue,
// which raises res_valid.
// Reset is asynchronous and leaves radix at 10.
// Result stall only holds back a NUL at the queue head; characters behind it
// wait in the two-entry queue, which then fills and raises char_stall.
module string_to_u64_parser_unit #(
	parameter int POSITION_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        radix_wr_en,
	input  logic [5:0]  radix_wr_data,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [63:0] value,
	output logic [1:0]  status,
	output logic [15:0] stop_index
);
	import s2u_pkg::*;

	logic [5:0] radix_q;

	// front -> queue
	logic     q_full, q_push;
	s2u_cls_t f_item;

	// queue -> back
	logic     q_valid, q_pop;
	s2u_cls_t b_item;

	// Base register; sampled by the back end once per string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_wr_en) begin
			radix_q <= radix_wr_data;
		end
	end

	// Front end: classify each character (space, sign, zero, x, digit value)
	s2u_front u_front (
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_byte  (char_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (f_item)
	);

	// Short queue decoupling classification from parsing
	s2u_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_item  (f_item),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_item  (b_item)
	);

	// Back end: parse phases, accumulate, build the result
	s2u_back #(
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix      (radix_q),
		.q_valid    (q_valid),
		.q_item     (b_item),
		.q_pop      (q_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.value      (value),
		.status     (status),
		.stop_index (stop_index)
	);

	// Bad base always reports a zero value at position zero
	a_badbase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_BADBASE) |-> (value == '0) && (stop_index == '0))
		else $error("bad base result not zero");

	// Converted digits always leave a nonzero stop position
	a_ok_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ((status == ST_OK) || (status == ST_OVF)) |-> (stop_index != '0))
		else $error("converted result with zero stop position");

	// Overflow saturates the value
	a_ovf_ones: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_OVF) |-> (value == '1))
		else $error("overflow result not all ones");

	// No character enters while the queue is full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("push into full queue");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// Testbench for string_to_u64_parser_unit.
//
// A driver and a monitor run as clocked always blocks. The driver takes bytes from
// pending_chars, which the initial block fills one phase at a time. Every accepted
// request goes through parse_char, a cycle-accurate-free model of the parser. Each NUL
// that parse_char sees queues one expected result in expected_results. The monitor
// compares each accepted result field by field with the oldest entry there.
// Between phases the initial block lets everything drain. Only then does it
// rewrite the radix register, so no string ever sees a radix change mid-flight.
module testbench;
	import s2u_pkg::*;

	// Radix register values
	localparam logic [5:0] RADIX_AUTO = 6'd0;
	localparam logic [5:0] BASE_MIN   = 6'd2;
	localparam logic [5:0] RADIX_OCT  = 6'd8;
	localparam logic [5:0] RADIX_DEC  = 6'd10;
	localparam logic [5:0] RADIX_HEX  = 6'd16;
	localparam logic [5:0] BASE_MAX   = 6'd36;
	localparam logic [5:0] RADIX_TOP  = 6'd63;

	localparam logic [7:0]  NUL      = 8'h00;
	localparam logic [7:0]  NO_DIGIT = 8'hFF;
	localparam logic [15:0] POS_MAX  = 16'hFFFF;

	localparam int GAP_MAX          = 13;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 8;
	localparam int RANDOM_ITEMS     = 1650;
	localparam int LONG_HOLD_PHASE  = 2;

	typedef enum logic [2:0] {
		PS_SPACE, PS_SIGN, PS_ZERO, PS_PREFIX, PS_DIGITS, PS_DONE
	} parse_state_e;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic [15:0] stop_index;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        radix_wr_en = 1'b0;
	logic [5:0]  radix_wr_data = RADIX_RESET;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  char_byte = NUL;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [63:0] value;
	logic [1:0]  status;
	logic [15:0] stop_index;

	string_to_u64_parser_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix_wr_en  (radix_wr_en),
		.radix_wr_data(radix_wr_data),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_byte    (char_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.value        (value),
		.status       (status),
		.stop_index   (stop_index)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stimulus and expectations
	logic [7:0]    pending_chars[$];
	parse_result_t expected_results[$];

	// Knobs owned by the initial block
	logic sender_idles = 1'b0;
	logic receiver_idles = 1'b0;
	logic long_hold_req = 1'b0;

	int mismatches = 0;

	// ---------------------------------------------------------------
	// Parser model: per-string state plus a shadow of the radix register
	// ---------------------------------------------------------------
	logic [5:0]   radix_shadow = RADIX_RESET;
	parse_state_e pstate = PS_SPACE;
	logic         neg_flag = 1'b0;
	logic         wrap_flag = 1'b0;
	logic [63:0]  acc = '0;
	logic [5:0]   base_in_use = '0;
	logic [15:0]  char_pos = '0;
	logic [15:0]  stop_pos = '0;
	logic         got_digit = 1'b0;

	function automatic logic [7:0] digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "Z") return c - "A" + 8'd10;
		if (c >= "a" && c <= "z") return c - "a" + 8'd10;
		return NO_DIGIT;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] p);
		return (p == POS_MAX) ? POS_MAX : p + 16'd1;
	endfunction

	// One digit of the active base, or the end of the number.
	// Overflow is exact: the product is formed wide and the upper bits checked.
	function automatic void accumulate(input logic [7:0] c, input logic [15:0] pos);
		logic [7:0]  d;
		logic [70:0] wide;
		d = digit_value(c);
		if (d >= base_in_use) begin
			pstate = PS_DONE;
			return;
		end
		wide = 71'(acc) * 71'(base_in_use) + 71'(d);
		if (wide[70:64] != '0) wrap_flag = 1'b1;
		acc = wide[63:0];
		got_digit = 1'b1;
		stop_pos = sat_inc(pos);
		pstate = PS_DIGITS;
	endfunction

	// First byte after blanks and sign: the radix register is sampled here.
	function automatic void choose_base(input logic [7:0] c, input logic [15:0] pos);
		logic [5:0] r;
		r = radix_shadow;
		if ((r == RADIX_AUTO || r == RADIX_HEX) && c == "0") begin
			// a leading zero counts as a digit; a following x may still switch to hex
			base_in_use = (r == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
			acc = '0;
			got_digit = 1'b1;
			stop_pos = sat_inc(pos);
			pstate = PS_ZERO;
			return;
		end
		if (r == RADIX_AUTO) begin
			r = RADIX_DEC;
		end else if (r < BASE_MIN || r > BASE_MAX) begin
			base_in_use = '0;
			pstate = PS_DONE;
			return;
		end
		base_in_use = r;
		accumulate(c, pos);
	endfunction

	function automatic void clear_string();
		pstate = PS_SPACE;
		neg_flag = 1'b0;
		wrap_flag = 1'b0;
		acc = '0;
		base_in_use = '0;
		char_pos = '0;
		stop_pos = '0;
		got_digit = 1'b0;
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		logic [15:0]   pos;
		parse_result_t r;
		pos = char_pos;
		case (pstate)
			PS_SPACE: begin
				if (!is_blank(c)) begin
					if (c == "-" || c == "+") begin
						neg_flag = (c == "-");
						pstate = PS_SIGN;
					end else begin
						choose_base(c, pos);
					end
				end
			end
			PS_SIGN: choose_base(c, pos);
			PS_ZERO: begin
				if (c == "x" || c == "X") pstate = PS_PREFIX;
				else accumulate(c, pos);
			end
			PS_PREFIX: begin
				// "0x" only counts as a prefix when a hex digit follows
				if (digit_value(c) < RADIX_HEX) begin
					base_in_use = RADIX_HEX;
					acc = '0;
					wrap_flag = 1'b0;
					accumulate(c, pos);
				end else begin
					pstate = PS_DONE;
				end
			end
			PS_DIGITS: accumulate(c, pos);
			default: ;
		endcase
		char_pos = sat_inc(char_pos);
		if (c != NUL) return;

		if (base_in_use == '0) begin
			r = '{value: '0, status: ST_BADBASE, stop_index: '0};
		end else if (!got_digit) begin
			r = '{value: '0, status: ST_NODIG, stop_index: '0};
		end else if (wrap_flag) begin
			r = '{value: '1, status: ST_OVF, stop_index: stop_pos};
		end else begin
			r = '{value: neg_flag ? -acc : acc, status: ST_OK, stop_index: stop_pos};
		end
		expected_results.push_back(r);
		clear_string();
	endfunction

	// ---------------------------------------------------------------
	// Driver: one request per free slot, random gap drawn per request
	// ---------------------------------------------------------------
	int unsigned send_gap = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall) parse_char(char_byte);
			// the slot is free when nothing is offered or the offer was just taken
			if (!char_valid || !char_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					char_valid <= 1'b0;
				end else if (pending_chars.size() != 0) begin
					char_valid <= 1'b1;
					char_byte <= pending_chars.pop_front();
					send_gap <= sender_idles ? $urandom_range(0, GAP_MAX) : 0;
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: checks results and drives res_stall
	// ---------------------------------------------------------------
	int unsigned recv_gap = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	function automatic void check_field(input string what, input logic [63:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: value %0h status %0d stop %0d",
						$time, value, status, stop_index);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("value", want.value, value);
					check_field("status", 64'(want.status), 64'(status));
					check_field("stop_index", 64'(want.stop_index), 64'(stop_index));
				end
				recv_gap = receiver_idles ? $urandom_range(0, GAP_MAX) : 0;
			end
			// A long hold lets plain characters pile up behind held NULs until
			// the input queue fills and char_stall rises.
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
				res_stall <= 1'b1;
			end else if (recv_gap != 0) begin
				recv_gap--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [7:0] digit_char(input int unsigned v);
		if (v < 10) return 8'("0" + v);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
	endfunction

	function automatic logic [7:0] blank_char();
		int unsigned k;
		k = $urandom_range(0, 5);
		return (k == 5) ? " " : 8'(9 + k);
	endfunction

	function automatic logic [7:0] sign_char();
		return $urandom_range(0, 1) ? "-" : "+";
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
		pending_chars.push_back(NUL);
	endtask

	// One NUL-terminated string. Mostly well-formed numbers for the current radix,
	// some malformed prefixes, some byte noise.
	task automatic push_random_string(inout int unsigned used);
		int unsigned mark, kind, base, len;
		mark = pending_chars.size();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(0, 12)) pending_chars.push_back(8'($urandom_range(1, 255)));
		end else if (kind == 1) begin
			case ($urandom_range(0, 3))
				0: begin
					// two signs in a row
					pending_chars.push_back(sign_char());
					pending_chars.push_back(sign_char());
					repeat ($urandom_range(1, 4)) pending_chars.push_back(digit_char($urandom_range(0, 9)));
				end
				1: begin
					// blank after the sign
					pending_chars.push_back(sign_char());
					pending_chars.push_back(blank_char());
					pending_chars.push_back(digit_char($urandom_range(1, 9)));
				end
				2: begin
					// hex prefix with no hex digit after it
					pending_chars.push_back("0");
					pending_chars.push_back($urandom_range(0, 1) ? "x" : "X");
					pending_chars.push_back(8'("g" + $urandom_range(0, 19)));
					pending_chars.push_back(digit_char($urandom_range(0, 7)));
				end
				default: pending_chars.push_back(sign_char());
			endcase
		end else begin
			repeat ($urandom_range(0, 3)) pending_chars.push_back(blank_char());
			case ($urandom_range(0, 2))
				1: pending_chars.push_back("+");
				2: pending_chars.push_back("-");
				default: ;
			endcase
			base = radix_shadow;
			if (radix_shadow == RADIX_AUTO) begin
				case ($urandom_range(0, 2))
					0: begin
						pending_chars.push_back("0");
						pending_chars.push_back($urandom_range(0, 1) ? "x" : "X");
						base = RADIX_HEX;
					end
					1: begin
						pending_chars.push_back("0");
						base = RADIX_OCT;
					end
					default: begin
						base = RADIX_DEC;
						pending_chars.push_back(digit_char($urandom_range(1, 9)));
					end
				endcase
			end else if (radix_shadow == RADIX_HEX && $urandom_range(0, 1)) begin
				pending_chars.push_back("0");
				pending_chars.push_back($urandom_range(0, 1) ? "x" : "X");
			end else if (radix_shadow < BASE_MIN || radix_shadow > BASE_MAX) begin
				base = $urandom_range(BASE_MIN, BASE_MAX);
			end
			// long runs reach overflow in most bases
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, base <= 4 ? 68 : 30)
				: $urandom_range(1, 8);
			repeat (len) pending_chars.push_back(digit_char($urandom_range(0, base - 1)));
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 4)) pending_chars.push_back(8'($urandom_range(1, 255)));
		end
		pending_chars.push_back(NUL);
		used += pending_chars.size() - mark;
	endtask

	task automatic fill_random(input int unsigned budget);
		int unsigned used;
		used = 0;
		while (used < budget) push_random_string(used);
	endtask

	// Wait until every request went in and every result came out.
	task automatic drain();
		do @(negedge clk);
		while (pending_chars.size() != 0 || char_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input logic [5:0] r);
		@(posedge clk);
		radix_wr_en <= 1'b1;
		radix_wr_data <= r;
		@(posedge clk);
		radix_wr_en <= 1'b0;
		radix_shadow = r;
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		logic [5:0] plan[$];
		bit         seeded[64];
		plan = '{RADIX_DEC, RADIX_AUTO, RADIX_HEX, BASE_MIN, BASE_MAX, RADIX_OCT, 6'd1,
			RADIX_TOP, 6'd37, RADIX_AUTO, 6'd7, RADIX_HEX, 6'd35, 6'd3, RADIX_DEC};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// First phase runs on the reset radix, no write before it.
		for (int p = 0; p < plan.size(); p++) begin
			if (p != 0) write_radix(plan[p]);
			sender_idles = $urandom_range(0, 2) != 0;
			receiver_idles = $urandom_range(0, 2) != 0;
			if (!seeded[plan[p]]) begin
				seeded[plan[p]] = 1'b1;
				case (plan[p])
					RADIX_DEC: begin
						// all blank kinds, minus, stop on a letter
						for (int i = 9; i <= 13; i++) pending_chars.push_back(8'(i));
						push_text(" -12x");
						push_text("+-5");
						push_text("");
						pending_chars.push_back(8'hFF);
						pending_chars.push_back(NUL);
					end
					RADIX_AUTO: begin
						push_text("0x1F");
						push_text("0xg");
						push_text("017");
						push_text("-9");
					end
					RADIX_HEX: begin
						push_text("ffffffffffffffff");
						push_text("-0x1");
					end
					BASE_MAX: push_text("zzzzzzzzzzzzz");
					6'd1: push_text("5");
					default: ;
				endcase
			end
			if (p == LONG_HOLD_PHASE) begin
				sender_idles = 1'b0;
				long_hold_req = 1'b1;
			end
			fill_random(RANDOM_ITEMS / plan.size());
			drain();
		end

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("string_to_u64_parser_unit test passed");
		end else begin
			$display("string_to_u64_parser_unit test failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("string_to_u64_parser_unit test failed");
		$finish;
	end

endmodule
